// File: rtl/gbfs_pkg.sv
`timescale 1ns / 1ps
package gbfs_pkg;

  localparam int unsigned DefGridW = 32;
  localparam int unsigned DefGridH = 32;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic       blocked;
    logic [4:0] goal_x;
    logic [4:0] goal_y;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       found;
    logic       cell_visited;
    logic [2:0] parent_dir;
    logic       cell_blocked;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic init_step;  // clear one map cell after reset
    logic load;       // capture the input item
    logic clr_step;   // clear one visited row
    logic seed;       // mark start, push it
    logic pop_req;    // read fifo head
    logic pop_take;   // latch popped cell, test goal
    logic probe;      // issue neighbour read
    logic probe_chk;  // evaluate neighbour
    logic write_op;   // obstacle write
    logic read_req;   // issue cell read
    logic read_take;  // form read result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_done;
    logic clr_done;
    logic fifo_empty;
    logic is_goal;
    logic dir_last;
  } sts_t;

  // 8 neighbour steps, 0 up clockwise
  function automatic logic signed [1:0] step_dx(input logic [2:0] d);
    case (d)
      3'd1, 3'd2, 3'd3: step_dx = 2'sd1;
      3'd5, 3'd6, 3'd7: step_dx = -2'sd1;
      default:          step_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [2:0] d);
    case (d)
      3'd0, 3'd1, 3'd7: step_dy = -2'sd1;
      3'd3, 3'd4, 3'd5: step_dy = 2'sd1;
      default:          step_dy = 2'sd0;
    endcase
  endfunction

endpackage

// File: rtl/gbfs_ctrl.sv
`timescale 1ns / 1ps
module gbfs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  logic             in_range_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output gbfs_pkg::cmd_t   cmd,
  input  gbfs_pkg::sts_t   sts,
  output logic             res_found,
  output logic             res_status
);
  import gbfs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLEAR  = 12'b000000000010,
    S_SEED   = 12'b000000000100,
    S_POPREQ = 12'b000000001000,
    S_POP    = 12'b000000010000,
    S_PROBE  = 12'b000000100000,
    S_CHECK  = 12'b000001000000,
    S_RDREQ  = 12'b000010000000,
    S_RDTAKE = 12'b000100000000,
    S_OUT    = 12'b001000000000,
    S_WRITE  = 12'b010000000000,
    S_INIT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;
  logic   stat_r, stat_nxt;

  // out_valid holds in S_OUT; the next item is taken once the result has left
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign res_found  = found_r;
  assign res_status = stat_r;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    stat_nxt  = stat_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          found_nxt = 1'b0;
          stat_nxt  = ~in_range_ok && (in_opcode != OP_NONE);
          if (!in_range_ok || in_opcode == OP_NONE) begin
            state_nxt = S_OUT;
          end else begin
            case (in_opcode)
              OP_WRITE:  state_nxt = S_WRITE;
              OP_SEARCH: state_nxt = S_CLEAR;
              default:   state_nxt = S_RDREQ;
            endcase
          end
        end
      end
      S_WRITE: begin
        cmd.write_op = 1'b1;
        state_nxt    = S_OUT;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_POPREQ;
      end
      S_POPREQ: begin
        if (sts.fifo_empty) begin
          state_nxt = S_OUT;
        end else begin
          cmd.pop_req = 1'b1;
          state_nxt   = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        if (sts.is_goal) begin
          found_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.probe_chk = 1'b1;
        state_nxt     = sts.dir_last ? S_POPREQ : S_PROBE;
      end
      S_RDREQ: begin
        cmd.read_req = 1'b1;
        state_nxt    = S_RDTAKE;
      end
      S_RDTAKE: begin
        cmd.read_take = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      found_r <= 1'b0;
      stat_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      stat_r  <= stat_nxt;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_found) && $stable(res_status))
    else $error("result dropped under stall");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and output both open");
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_found |-> !res_status)
    else $error("found with bad status");
`endif
endmodule

// File: rtl/gbfs_dpath.sv
`timescale 1ns / 1ps
module gbfs_dpath #(
  parameter int unsigned GRID_W = gbfs_pkg::DefGridW,
  parameter int unsigned GRID_H = gbfs_pkg::DefGridH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gbfs_pkg::in_item_t   in_item,
  output logic                 in_range_ok,
  input  gbfs_pkg::cmd_t       cmd,
  output gbfs_pkg::sts_t       sts,
  output logic                 rd_visited,
  output logic [2:0]           rd_parent,
  output logic                 rd_blocked
);
  import gbfs_pkg::*;

  localparam int unsigned XW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int unsigned YW    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned PW    = $clog2(CELLS + 1);

  // cells are stored at address {y, x}
  logic                 obst_mem [1 << AW];
  logic [2:0]           par_mem  [1 << AW];
  logic [AW-1:0]        fifo_mem [CELLS];
  // visited kept as one word per row: row clear is one write
  logic [GRID_W-1:0]    vis_mem  [GRID_H];

  logic [XW-1:0] sx_r, gx_r, cx_r;
  logic [YW-1:0] sy_r, gy_r, cy_r;
  logic          blk_r;
  logic [PW-1:0] head_r, tail_r;
  logic [YW-1:0] clr_row_r;
  logic [AW-1:0] init_r;
  logic [2:0]    dir_r;
  logic [AW-1:0] pop_q_r;
  logic          nb_ok_r;
  logic [XW-1:0] nx_r;
  logic [YW-1:0] ny_r;
  logic          obst_q_r;
  logic [GRID_W-1:0] vis_q_r;
  logic [2:0]    par_q_r;

  logic [5:0] ix, iy, igx, igy;
  assign ix  = {1'b0, in_item.cell_x};
  assign iy  = {1'b0, in_item.cell_y};
  assign igx = {1'b0, in_item.goal_x};
  assign igy = {1'b0, in_item.goal_y};
  always_comb begin
    in_range_ok = (32'(ix) < GRID_W) && (32'(iy) < GRID_H);
    if (in_item.opcode == OP_SEARCH)
      in_range_ok = in_range_ok && (32'(igx) < GRID_W) && (32'(igy) < GRID_H);
  end

  // neighbour coordinates for the current direction
  logic signed [XW+1:0] nxs;
  logic signed [YW+1:0] nys;
  logic                 nb_in;
  assign nxs   = $signed({2'b00, cx_r}) + (XW+2)'(step_dx(dir_r));
  assign nys   = $signed({2'b00, cy_r}) + (YW+2)'(step_dy(dir_r));
  assign nb_in = (nxs >= 0) && (nys >= 0) && (32'(nxs) < GRID_W) && (32'(nys) < GRID_H);

  logic [XW-1:0] popx;
  logic [YW-1:0] popy;
  assign popx = pop_q_r[XW-1:0];
  assign popy = pop_q_r[AW-1:XW];

  logic push_ok;
  assign push_ok = nb_ok_r && !obst_q_r && !vis_q_r[nx_r];

  assign sts.init_done  = (init_r == '1);
  assign sts.clr_done   = (32'(clr_row_r) == GRID_H - 1);
  assign sts.fifo_empty = (head_r == tail_r);
  assign sts.is_goal    = (popx == gx_r) && (popy == gy_r);
  assign sts.dir_last   = (dir_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      clr_row_r <= '0;
      init_r    <= '0;
      dir_r     <= '0;
    end else begin
      if (cmd.init_step) init_r <= init_r + 1'b1;
      if (cmd.load) clr_row_r <= '0;
      else if (cmd.clr_step) clr_row_r <= clr_row_r + 1'b1;
      if (cmd.seed) begin
        head_r <= '0;
        tail_r <= PW'(1);
      end
      if (cmd.pop_req) head_r <= head_r + 1'b1;
      if (cmd.pop_take) dir_r <= '0;
      if (cmd.probe_chk) begin
        dir_r <= dir_r + 1'b1;
        if (push_ok) tail_r <= tail_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r  <= XW'(in_item.cell_x);
      sy_r  <= YW'(in_item.cell_y);
      gx_r  <= XW'(in_item.goal_x);
      gy_r  <= YW'(in_item.goal_y);
      blk_r <= in_item.blocked;
    end
    if (cmd.pop_req) pop_q_r <= fifo_mem[head_r[PW-2:0]];
    if (cmd.pop_take) begin
      cx_r <= popx;
      cy_r <= popy;
    end
    if (cmd.probe) begin
      nb_ok_r  <= nb_in;
      nx_r     <= nxs[XW-1:0];
      ny_r     <= nys[YW-1:0];
      obst_q_r <= obst_mem[{nys[YW-1:0], nxs[XW-1:0]}];
      vis_q_r  <= vis_mem[nys[YW-1:0]];
    end
    if (cmd.read_req) begin
      obst_q_r <= obst_mem[{sy_r, sx_r}];
      vis_q_r  <= vis_mem[sy_r];
      par_q_r  <= par_mem[{sy_r, sx_r}];
    end
  end

  // memory writes; after reset one cell a cycle is cleared
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      obst_mem[init_r]           <= 1'b0;
      vis_mem[init_r[AW-1:XW]]   <= '0;
    end
    if (cmd.write_op) obst_mem[{sy_r, sx_r}] <= blk_r;
    if (cmd.clr_step) vis_mem[clr_row_r] <= '0;
    if (cmd.seed) begin
      vis_mem[sy_r][sx_r] <= 1'b1;
      fifo_mem[0]          <= {sy_r, sx_r};
    end
    if (cmd.probe_chk && push_ok) begin
      vis_mem[ny_r][nx_r] <= 1'b1;
      fifo_mem[tail_r[PW-2:0]] <= {ny_r, nx_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed) par_mem[{sy_r, sx_r}] <= 3'd0;
    else if (cmd.probe_chk && push_ok) par_mem[{ny_r, nx_r}] <= dir_r;
  end

  logic          rv_r, rb_r;
  logic [2:0]    rp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      rp_r <= '0;
      rb_r <= 1'b0;
    end else if (cmd.load) begin
      rv_r <= 1'b0;
      rp_r <= '0;
      rb_r <= 1'b0;
    end else if (cmd.read_take) begin
      rv_r <= vis_q_r[sx_r];
      rp_r <= vis_q_r[sx_r] ? par_q_r : 3'd0;
      rb_r <= obst_q_r;
    end
  end
  assign rd_visited = rv_r;
  assign rd_parent  = rp_r;
  assign rd_blocked = rb_r;

`ifndef SYNTHESIS
  a_fifo_order: assert property (@(posedge clk) disable iff (!rst_n) head_r <= tail_r)
    else $error("frontier head passed tail");
  a_fifo_cap: assert property (@(posedge clk) disable iff (!rst_n) 32'(tail_r) <= CELLS)
    else $error("frontier overflow");
  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seed |=> tail_r == PW'(1) && head_r == '0)
    else $error("seed did not reset frontier");
`endif
endmodule

// File: rtl/grid_bfs_path_search_top.sv
`timescale 1ns / 1ps
// Breadth-first search engine over an 8-connected obstacle grid.
// Input channel (in_valid/in_ready, in_item): opcode 0 writes one obstacle bit,
// 1 runs a search from (cell_x, cell_y) to (goal_x, goal_y), 2 reads a cell's
// visited mark, parent direction and obstacle bit. Every item gives exactly
// one result on out_valid/out_ready, out_item.
// One item is in flight at a time; in_ready rises again after its result left.
// A write passes through S_WRITE, a read through S_RDREQ and S_RDTAKE, and
// an item with bad coordinates or opcode 3 goes straight to S_OUT.
// A search first clears the visited rows, one row a cycle, then pops cells
// from the frontier; a popped cell that is not the goal has its eight
// neighbours probed in turn, each in a probe state and then a check state.
// Reset (rst_n low, synchronous) puts the controller in its init state and
// empties the frontier; the block then clears the obstacle map and visited
// marks one cell a cycle with in_ready low, and then goes idle. A stalled
// receiver holds the result in place and no new item is taken until it is
// accepted.
module grid_bfs_path_search_top #(
  parameter int unsigned GRID_W = gbfs_pkg::DefGridW,
  parameter int unsigned GRID_H = gbfs_pkg::DefGridH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbfs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output gbfs_pkg::out_item_t out_item
);
  import gbfs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic range_ok, res_found, res_status;
  logic rd_visited, rd_blocked;
  logic [2:0] rd_parent;

  gbfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_item.opcode), .in_range_ok(range_ok),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .sts(sts),
    .res_found(res_found), .res_status(res_status)
  );

  gbfs_dpath #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .in_item(in_item), .in_range_ok(range_ok),
    .cmd(cmd), .sts(sts),
    .rd_visited(rd_visited), .rd_parent(rd_parent), .rd_blocked(rd_blocked)
  );

  always_comb begin
    out_item              = '0;
    out_item.status       = res_status;
    out_item.found        = res_found;
    out_item.cell_visited = rd_visited;
    out_item.parent_dir   = rd_parent;
    out_item.cell_blocked = rd_blocked;
  end
endmodule
